// ===== sv/cpfbp_pkg.sv =====
// ----------------------------------------------------------------------------
// cpfbp_pkg - shared types and constants of the cut-off path flag block parser
// Record kinds, the result record layout, and the register map.
// ----------------------------------------------------------------------------
package cpfbp_pkg;

   localparam int unsigned PATH_W      = 5;
   localparam int unsigned SIZE_W      = 32;
   localparam int unsigned FLAGS_W     = 8;
   localparam int unsigned FCOUNT_W    = 4;
   localparam int unsigned SCAN_W      = 16;
   localparam int unsigned HDR_W       = 3;
   localparam int unsigned RSP_DATA_W  = 56;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   // Size bytes at the head of each path; the last one carries the record.
   localparam logic [1:0] LAST_SIZE_BYTE = 2'd3;
   // Flags held in one flag byte.
   localparam logic [FCOUNT_W-1:0] FLAGS_PER_BYTE = 4'd8;

   // Register index, taken from paddr[2] (byte address 4*i).
   localparam logic REG_SCAN_POINTS = 1'b0;

   typedef enum logic {
      KIND_SIZE = 1'b0,
      KIND_FLAG = 1'b1
   } record_kind_type;

   typedef struct packed {
      record_kind_type      kind;
      logic                 block_done;
      logic                 path_done;
      logic [FCOUNT_W-1:0]  flag_count;
      logic [FLAGS_W-1:0]   flag_bits;
      logic [SIZE_W-1:0]    path_size;
      logic [PATH_W-1:0]    path_index;
   } rsp_rec_type;

endpackage

// ===== sv/cutoff_path_flag_block_parser_core.sv =====
// ----------------------------------------------------------------------------
// cutoff_path_flag_block_parser_core - cut-off path flag block parser
// Walks a block of NUM_PATHS paths byte by byte: 4-byte LE size, then flag
// bytes; emits one size record per path and one flag record per flag byte.
// ----------------------------------------------------------------------------
//  channel   dir   handshake               payload
//  req_*     in    tvalid/tready           tdata: block_byte; tuser: block_start
//  rsp_*     out   tvalid/tready           tdata: record fields; tuser: kind;
//                                          tlast: block_done
//  csr_*     in    APB psel/penable        scan_points at byte address 0
//
//  One byte per cycle while req_tready is high. The parse state and the
//  output register (or the skid entry, if the output stalls) update in the
//  cycle a byte is taken, so throughput is set by the single byte-wide parse step.
//  A two-entry output (register plus skid) keeps req_tready high while one
//  result waits; it drops only when both entries are full.
//  After reset the parser is idle until a word with block_start set;
//  scan_points resets to 0.
// ----------------------------------------------------------------------------
module cutoff_path_flag_block_parser_core
   import cpfbp_pkg::*;
#(
   parameter int unsigned NUM_PATHS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   // input words
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] block_byte
   input  logic                  req_tuser,   // [0] block_start
   // result words
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [4:0] path_index, [36:5] path_size, [44:37] flag_bits,
   // [48:45] flag_count, [49] path_done, [55:50] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,   // [0] record_kind
   output logic                  rsp_tlast,   // block_done
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam logic [PATH_W:0] LastPath = (PATH_W+1)'(NUM_PATHS - 1);

   // parse state
   logic [PATH_W-1:0]   path_ff,     path_in;
   logic [HDR_W-1:0]    hdr_cnt_ff,  hdr_cnt_in;
   logic [SIZE_W-1:0]   size_acc_ff, size_acc_in;
   logic [SIZE_W-1:0]   consumed_ff, consumed_in;
   logic [SCAN_W-1:0]   emitted_ff,  emitted_in;
   logic                finished_ff, finished_in;
   logic [SCAN_W-1:0]   scan_points_ff;

   // output register and skid
   logic                out_valid_ff,  out_valid_in;
   rsp_rec_type         out_word_ff,   out_word_in;
   logic                skid_valid_ff, skid_valid_in;
   rsp_rec_type         skid_word_ff,  skid_word_in;

   logic                req_fire;
   logic                active;
   logic [PATH_W-1:0]   eff_path;
   logic [HDR_W-1:0]    eff_hdr;
   logic [SIZE_W-1:0]   eff_acc;
   logic [SIZE_W-1:0]   eff_consumed;
   logic [SCAN_W-1:0]   eff_emitted;
   logic [SIZE_W-1:0]   acc_new;
   logic [SIZE_W-1:0]   consumed_new;
   logic [SCAN_W:0]     flags_left;
   logic [FCOUNT_W-1:0] count;
   logic [8:0]          flag_mask;
   logic                last_path;
   logic                end_path;
   logic                res_valid;
   rsp_rec_type         res_word;
   logic                pop;
   logic                csr_write;

   assign req_tready = !skid_valid_ff;
   assign req_fire   = req_tvalid && req_tready;

   // block_start restarts the parse on this very byte
   assign eff_path     = req_tuser ? '0 : path_ff;
   assign eff_hdr      = req_tuser ? '0 : hdr_cnt_ff;
   assign eff_acc      = req_tuser ? '0 : size_acc_ff;
   assign eff_consumed = req_tuser ? '0 : consumed_ff;
   assign eff_emitted  = req_tuser ? '0 : emitted_ff;
   assign active       = req_fire && (req_tuser || !finished_ff);

   assign acc_new      = eff_acc | (SIZE_W'(req_tdata) << {eff_hdr[1:0], 3'b000});
   assign consumed_new = eff_consumed + SIZE_W'(1);
   assign flags_left   = {1'b0, scan_points_ff} - {1'b0, eff_emitted};
   assign last_path    = ({1'b0, eff_path} == LastPath);

   always_comb begin
      if (eff_emitted >= scan_points_ff) begin
         count = '0;
      end else if (flags_left > (SCAN_W+1)'(FLAGS_PER_BYTE)) begin
         count = FLAGS_PER_BYTE;
      end else begin
         count = flags_left[FCOUNT_W-1:0];
      end
   end

   assign flag_mask = (9'd1 << count) - 9'd1;

   always_comb begin
      path_in     = path_ff;
      hdr_cnt_in  = hdr_cnt_ff;
      size_acc_in = size_acc_ff;
      consumed_in = consumed_ff;
      emitted_in  = emitted_ff;
      finished_in = finished_ff;
      res_valid   = 1'b0;
      res_word    = '0;
      end_path    = 1'b0;
      if (active) begin
         path_in              = eff_path;
         consumed_in          = eff_consumed;
         emitted_in           = eff_emitted;
         finished_in          = 1'b0;
         res_word.path_index  = eff_path;
         if (!eff_hdr[2]) begin
            // size byte: shift into the accumulator
            hdr_cnt_in  = eff_hdr + HDR_W'(1);
            size_acc_in = acc_new;
            if (eff_hdr[1:0] == LAST_SIZE_BYTE) begin
               res_valid          = 1'b1;
               res_word.kind      = KIND_SIZE;
               res_word.path_size = acc_new;
               end_path           = (acc_new == '0);
            end
         end else begin
            // flag byte
            hdr_cnt_in          = eff_hdr;
            size_acc_in         = eff_acc;
            consumed_in         = consumed_new;
            emitted_in          = eff_emitted + SCAN_W'(count);
            res_valid           = 1'b1;
            res_word.kind       = KIND_FLAG;
            res_word.path_size  = eff_acc;
            res_word.flag_bits  = req_tdata & flag_mask[7:0];
            res_word.flag_count = count;
            end_path            = (consumed_new >= eff_acc);
         end
         if (end_path) begin
            res_word.path_done  = 1'b1;
            res_word.block_done = last_path;
            hdr_cnt_in          = '0;
            size_acc_in         = '0;
            consumed_in         = '0;
            emitted_in          = '0;
            if (last_path) begin
               finished_in = 1'b1;
            end else begin
               path_in = eff_path + PATH_W'(1);
            end
         end
      end
   end

   // output register with one skid entry
   assign pop = out_valid_ff && rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (pop || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res_valid;
            out_word_in  = res_word;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_word_in  = res_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         path_ff       <= '0;
         hdr_cnt_ff    <= '0;
         size_acc_ff   <= '0;
         consumed_ff   <= '0;
         emitted_ff    <= '0;
         finished_ff   <= 1'b1;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         path_ff       <= path_in;
         hdr_cnt_ff    <= hdr_cnt_in;
         size_acc_ff   <= size_acc_in;
         consumed_ff   <= consumed_in;
         emitted_ff    <= emitted_in;
         finished_ff   <= finished_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_word_ff.kind;
   assign rsp_tlast  = out_word_ff.block_done;
   assign rsp_tdata  = {6'b000000, out_word_ff.path_done, out_word_ff.flag_count,
                        out_word_ff.flag_bits, out_word_ff.path_size,
                        out_word_ff.path_index};

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_points_ff <= '0;
      end else if (csr_write && (csr_paddr[2] == REG_SCAN_POINTS)) begin
         scan_points_ff <= csr_pwdata[SCAN_W-1:0];
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_SCAN_POINTS: csr_prdata = CSR_DATA_W'(scan_points_ff);
         default:         csr_prdata = '0;
      endcase
   end

endmodule

// ===== sv/cpfbp_checker.sv =====
// ----------------------------------------------------------------------------
// cpfbp_checker - port-level checks of the cut-off path flag block parser
// Watches the result channel for record layout and handshake behavior.
// ----------------------------------------------------------------------------
module cpfbp_checker
   import cpfbp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser,
   input logic                  rsp_tlast
);

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[48:45] <= FLAGS_PER_BYTE)
      else $error("flag count above eight");

   a_size_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_SIZE) |-> rsp_tdata[48:37] == '0)
      else $error("size record carries flag data");

   a_last_ends_path: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[49])
      else $error("block end without path end");

endmodule

bind cutoff_path_flag_block_parser_core cpfbp_checker u_cpfbp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
